### hdl/p3d_pkg.sv
// Shared constants and types for the 3-D pooling block.
package p3d_pkg;

   localparam int VOL_DEPTH   = 16;
   localparam int VOL_HEIGHT  = 16;
   localparam int VOL_WIDTH   = 16;
   localparam int MAX_KERNEL  = 8;
   localparam int SAMPLE_BITS = 16;

   localparam int STORE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COORD_W     = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 15;
   localparam int DIM_W       = 4;
   localparam int VOLF_W      = 5;
   localparam int LIM_W       = 7;
   localparam int POS_W       = 12;
   localparam int TAP_W       = $clog2(MAX_KERNEL * MAX_KERNEL * MAX_KERNEL + 1);
   localparam int SUM_W       = SAMPLE_BITS + TAP_W;
   localparam int RES_W       = SUM_W + 1;
   localparam int DCNT_W      = $clog2(SUM_W);
   localparam int LIMB_W      = 32;
   localparam int LIMBS       = 4;
   localparam int PSUM_W      = LIMB_W * LIMBS;

   localparam int VOL_DIMS [3] = '{VOL_DEPTH, VOL_HEIGHT, VOL_WIDTH};

   localparam logic signed [RES_W-1:0] VAL_MAX =
      RES_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [RES_W-1:0] VAL_MIN = -VAL_MAX - RES_W'(1);
   localparam logic [SAMPLE_BITS-1:0] ROOT_HI  = SAMPLE_BITS'(64'd1 << (SAMPLE_BITS - 1));
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN =
      SAMPLE_BITS'(64'd1 << (SAMPLE_BITS - 1));

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POOL_MODE = 3'd0,
      CSR_EXTRA     = 3'd1,
      CSR_KERNEL    = 3'd2,
      CSR_STRIDE    = 3'd3,
      CSR_PAD       = 3'd4,
      CSR_DILATION  = 3'd5,
      CSR_VOLUME    = 3'd6
   } csr_idx_type;

   localparam logic [1:0] MODE_MAX   = 2'd0;
   localparam logic [1:0] MODE_AVG   = 2'd1;
   localparam logic [1:0] MODE_PNORM = 2'd2;

   localparam logic [2:0] AVG_BY_TAPS   = 3'd0;
   localparam logic [2:0] AVG_BY_KERNEL = 3'd1;

   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_COMPUTE = 1'b1;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_PZERO = 2'd2;
   localparam logic [1:0] STAT_SAT   = 2'd3;

endpackage

### hdl/p3d_if.sv
// Request and response channel interfaces for the 3-D pooling block.
interface p3d_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   req_type;
   logic [p3d_pkg::ADDR_W-1:0]             sample_addr;
   logic signed [p3d_pkg::SAMPLE_BITS-1:0] sample_value;
   logic [p3d_pkg::COORD_W-1:0]            out_d;
   logic [p3d_pkg::COORD_W-1:0]            out_h;
   logic [p3d_pkg::COORD_W-1:0]            out_w;

   modport source (output valid, req_type, sample_addr, sample_value, out_d, out_h, out_w,
                   input ready);
   modport sink (input valid, req_type, sample_addr, sample_value, out_d, out_h, out_w,
                 output ready);
endinterface

interface p3d_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [p3d_pkg::SAMPLE_BITS-1:0] result_value;
   logic [1:0]                             result_status;

   modport source (output valid, result_value, result_status, input ready);
   modport sink (input valid, result_value, result_status, output ready);
endinterface

### hdl/pooling_3d_max_avg_pnorm.sv
// 3-D max / average / p-norm pooling over one stored volume, with a shared iterative datapath.
//
// Load items write one sample into a 4096-entry volume store. A compute item returns one
// result. A small sequencer walks every kernel position, out-of-range positions included,
// and passes through one more state on each in-range tap for the registered store read.
// Average mode with division then runs a restoring divider over the SUM_W-bit sum (26 bits
// at 16-bit samples). P-norm mode raises each tap to the power p on one 32 x SAMPLE_BITS
// multiplier, one 32-bit limb per cycle, then finds the root by binary search, each step
// raising the midpoint to the power p on the same multiplier and comparing it with the sum.
// The block takes no item while a compute item is in flight or its result waits;
// configuration must be written only while idle.
module pooling_3d_max_avg_pnorm (
   input  logic                               clock,
   input  logic                               reset,
   p3d_req_if.sink                            req_chan,
   p3d_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [p3d_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [p3d_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SB = p3d_pkg::SAMPLE_BITS;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SETUP, ST_WALK, ST_READ, ST_POW, ST_ADDP,
      ST_FINISH, ST_DIV, ST_ROOT, ST_CMP, ST_SAT, ST_OUT
   } state_type;

   state_type state_ff;

   // configuration
   logic [1:0]  cfg_mode_ff;
   logic [2:0]  cfg_ep_ff;
   logic [11:0] cfg_kern_ff, cfg_strd_ff, cfg_pad_ff, cfg_dil_ff;
   logic [14:0] cfg_vol_ff;

   // window walk, index 0 depth, 1 height, 2 width
   logic [p3d_pkg::COORD_W-1:0]      coord_ff [3];
   logic [p3d_pkg::DIM_W-1:0]        kmax_ff  [3];
   logic [p3d_pkg::DIM_W-1:0]        dil_ff   [3];
   logic [p3d_pkg::LIM_W-1:0]        lim_ff   [3];
   logic signed [p3d_pkg::POS_W-1:0] start_ff [3];
   logic signed [p3d_pkg::POS_W-1:0] pos_ff   [3];
   logic [p3d_pkg::DIM_W-1:0]        kcnt_ff  [3];

   // accumulators
   logic [p3d_pkg::TAP_W-1:0]        tap_cnt_ff, kprod_ff, divisor_ff, rem_ff;
   logic signed [SB-1:0]             mx_ff;
   logic signed [p3d_pkg::SUM_W-1:0] sum_ff;
   logic [p3d_pkg::PSUM_W-1:0]       psum_ff;
   logic [p3d_pkg::LIMBS-1:0][p3d_pkg::LIMB_W-1:0] term_ff;
   logic [p3d_pkg::LIMB_W-1:0]       carry_ff;
   logic [1:0]                       limb_ff;
   logic [2:0]                       pcnt_ff;
   logic [SB-1:0]                    pow_base_ff, lo_ff, hi_ff;
   logic                             root_ph_ff, neg_ff;
   logic [p3d_pkg::SUM_W-1:0]        quo_ff;
   logic [p3d_pkg::DCNT_W-1:0]       dcnt_ff;
   logic signed [p3d_pkg::RES_W-1:0] res_ff;

   // response register
   logic                             rsp_val_ff;
   logic signed [SB-1:0]             rsp_value_ff;
   logic [1:0]                       rsp_status_ff;

   // volume store
   logic signed [SB-1:0]             vol_mem [p3d_pkg::STORE_DEPTH];
   logic signed [SB-1:0]             rd_data_ff;
   logic [p3d_pkg::ADDR_W-1:0]       rd_addr;
   logic [31:0]                      addr_full;
   logic                             req_acc, mem_we;

   // setup values per axis
   logic [p3d_pkg::DIM_W-1:0]        su_k [3];
   logic [p3d_pkg::DIM_W-1:0]        su_d [3];
   logic [p3d_pkg::LIM_W-1:0]        su_n [3];
   logic signed [p3d_pkg::POS_W-1:0] su_start [3];
   logic [p3d_pkg::DIM_W-1:0]        kf [3], df [3], sf [3], pf [3];
   logic [p3d_pkg::VOLF_W-1:0]       vf [3];
   logic [p3d_pkg::TAP_W-1:0]        su_kprod;
   logic                             su_kzero;

   // walk advance
   logic [p3d_pkg::DIM_W-1:0]        adv_kcnt [3];
   logic signed [p3d_pkg::POS_W-1:0] adv_pos [3];
   logic [2:0]                       ax_last, ax_in;
   logic                             adv_inc, all_in;

   // shared datapath
   logic [63:0]                      mul_full;
   logic [SB-1:0]                    tap_abs, root_mid;
   logic [p3d_pkg::TAP_W:0]          rem_sh, rem_sub;
   logic                             div_ge;
   logic [p3d_pkg::SUM_W-1:0]        quo_nxt, sum_abs;

   assign req_acc = req_chan.valid && req_chan.ready;
   assign mem_we  = req_acc && (req_chan.req_type == p3d_pkg::REQ_LOAD);

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_val_ff;
   assign rsp_chan.result_value  = rsp_value_ff;
   assign rsp_chan.result_status = rsp_status_ff;

   // per-axis window geometry from the registers
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         kf[a] = cfg_kern_ff[8 - 4*a +: 4];
         sf[a] = cfg_strd_ff[8 - 4*a +: 4];
         pf[a] = cfg_pad_ff[8 - 4*a +: 4];
         df[a] = cfg_dil_ff[8 - 4*a +: 4];
         vf[a] = cfg_vol_ff[10 - 5*a +: 5];
         su_k[a] = (32'(kf[a]) > p3d_pkg::MAX_KERNEL) ? p3d_pkg::DIM_W'(p3d_pkg::MAX_KERNEL)
                                                      : kf[a];
         su_d[a] = (df[a] == '0) ? p3d_pkg::DIM_W'(1) : df[a];
         su_n[a] = (32'(vf[a]) > p3d_pkg::VOL_DIMS[a]) ? p3d_pkg::LIM_W'(p3d_pkg::VOL_DIMS[a])
                                                       : p3d_pkg::LIM_W'(vf[a]);
         su_start[a] = $signed(p3d_pkg::POS_W'(coord_ff[a]) * p3d_pkg::POS_W'(sf[a])
                               - p3d_pkg::POS_W'(pf[a]));
      end
      su_kprod = p3d_pkg::TAP_W'(32'(su_k[0]) * 32'(su_k[1]) * 32'(su_k[2]));
      su_kzero = (su_k[0] == '0) || (su_k[1] == '0) || (su_k[2] == '0);
   end

   // odometer step over the kernel, width innermost
   always_comb begin
      adv_inc = 1'b1;
      for (int a = 2; a >= 0; a--) begin
         ax_last[a]  = (kcnt_ff[a] == kmax_ff[a] - p3d_pkg::DIM_W'(1));
         ax_in[a]    = !pos_ff[a][p3d_pkg::POS_W-1] &&
                       ($unsigned(pos_ff[a]) < p3d_pkg::POS_W'(lim_ff[a]));
         adv_kcnt[a] = kcnt_ff[a];
         adv_pos[a]  = pos_ff[a];
         if (adv_inc) begin
            if (ax_last[a]) begin
               adv_kcnt[a] = '0;
               adv_pos[a]  = start_ff[a];
            end else begin
               adv_kcnt[a] = kcnt_ff[a] + p3d_pkg::DIM_W'(1);
               adv_pos[a]  = pos_ff[a] + $signed(p3d_pkg::POS_W'(dil_ff[a]));
               adv_inc     = 1'b0;
            end
         end
      end
      all_in = &ax_in;
   end

   assign addr_full = (32'(pos_ff[0][p3d_pkg::LIM_W-1:0]) * 32'(p3d_pkg::VOL_HEIGHT)
                       + 32'(pos_ff[1][p3d_pkg::LIM_W-1:0])) * 32'(p3d_pkg::VOL_WIDTH)
                       + 32'(pos_ff[2][p3d_pkg::LIM_W-1:0]);
   assign rd_addr   = addr_full[p3d_pkg::ADDR_W-1:0];

   // shared multiplier: one limb of the running power per cycle
   assign mul_full = 64'(term_ff[limb_ff]) * 64'(pow_base_ff) + 64'(carry_ff);
   assign tap_abs  = $unsigned(rd_data_ff[SB-1] ? -rd_data_ff : rd_data_ff);
   assign root_mid = lo_ff + ((hi_ff - lo_ff + SB'(1)) >> 1);

   // restoring divider step
   assign rem_sh  = {rem_ff, quo_ff[p3d_pkg::SUM_W-1]};
   assign div_ge  = rem_sh >= {1'b0, divisor_ff};
   assign rem_sub = div_ge ? rem_sh - {1'b0, divisor_ff} : rem_sh;
   assign quo_nxt = {quo_ff[p3d_pkg::SUM_W-2:0], div_ge};
   assign sum_abs = $unsigned(sum_ff[p3d_pkg::SUM_W-1] ? -sum_ff : sum_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vol_mem[req_chan.sample_addr] <= req_chan.sample_value;
      end
      rd_data_ff <= vol_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rsp_val_ff  <= 1'b0;
         cfg_mode_ff <= p3d_pkg::MODE_MAX;
         cfg_ep_ff   <= '0;
         cfg_kern_ff <= 12'd546;
         cfg_strd_ff <= 12'd273;
         cfg_pad_ff  <= '0;
         cfg_dil_ff  <= 12'd273;
         cfg_vol_ff  <= 15'd16912;
      end else begin
         if (csr_we) begin
            case (p3d_pkg::csr_idx_type'(csr_index))
               p3d_pkg::CSR_POOL_MODE: cfg_mode_ff <= csr_wdata[1:0];
               p3d_pkg::CSR_EXTRA:     cfg_ep_ff   <= csr_wdata[2:0];
               p3d_pkg::CSR_KERNEL:    cfg_kern_ff <= csr_wdata[11:0];
               p3d_pkg::CSR_STRIDE:    cfg_strd_ff <= csr_wdata[11:0];
               p3d_pkg::CSR_PAD:       cfg_pad_ff  <= csr_wdata[11:0];
               p3d_pkg::CSR_DILATION:  cfg_dil_ff  <= csr_wdata[11:0];
               p3d_pkg::CSR_VOLUME:    cfg_vol_ff  <= csr_wdata;
               default: ;
            endcase
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_acc && (req_chan.req_type == p3d_pkg::REQ_COMPUTE)) begin
                  coord_ff[0] <= req_chan.out_d;
                  coord_ff[1] <= req_chan.out_h;
                  coord_ff[2] <= req_chan.out_w;
                  state_ff    <= ST_SETUP;
               end
            end

            ST_SETUP: begin
               for (int a = 0; a < 3; a++) begin
                  kmax_ff[a]  <= su_k[a];
                  dil_ff[a]   <= su_d[a];
                  lim_ff[a]   <= su_n[a];
                  start_ff[a] <= su_start[a];
                  pos_ff[a]   <= su_start[a];
                  kcnt_ff[a]  <= '0;
               end
               kprod_ff   <= su_kprod;
               tap_cnt_ff <= '0;
               mx_ff      <= p3d_pkg::SMP_MIN;
               sum_ff     <= '0;
               psum_ff    <= '0;
               if (cfg_mode_ff == p3d_pkg::MODE_PNORM && cfg_ep_ff == '0) begin
                  // zero exponent wins over an empty window
                  rsp_value_ff  <= '0;
                  rsp_status_ff <= p3d_pkg::STAT_PZERO;
                  rsp_val_ff    <= 1'b1;
                  state_ff      <= ST_OUT;
               end else if (su_kzero) begin
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_WALK;
               end
            end

            ST_WALK: begin
               if (all_in) begin
                  state_ff <= ST_READ;     // store read in flight
               end else begin
                  kcnt_ff  <= adv_kcnt;
                  pos_ff   <= adv_pos;
                  if (adv_inc) state_ff <= ST_FINISH;
               end
            end

            ST_READ: begin
               tap_cnt_ff <= tap_cnt_ff + p3d_pkg::TAP_W'(1);
               sum_ff     <= sum_ff + p3d_pkg::SUM_W'(rd_data_ff);
               if (rd_data_ff > mx_ff) mx_ff <= rd_data_ff;
               if (cfg_mode_ff == p3d_pkg::MODE_PNORM) begin
                  pow_base_ff <= tap_abs;
                  term_ff     <= p3d_pkg::PSUM_W'(1);
                  carry_ff    <= '0;
                  limb_ff     <= '0;
                  pcnt_ff     <= '0;
                  root_ph_ff  <= 1'b0;
                  state_ff    <= ST_POW;
               end else begin
                  kcnt_ff  <= adv_kcnt;
                  pos_ff   <= adv_pos;
                  state_ff <= adv_inc ? ST_FINISH : ST_WALK;
               end
            end

            ST_POW: begin
               term_ff[limb_ff] <= mul_full[p3d_pkg::LIMB_W-1:0];
               if (limb_ff == 2'(p3d_pkg::LIMBS - 1)) begin
                  carry_ff <= '0;
                  limb_ff  <= '0;
                  pcnt_ff  <= pcnt_ff + 3'd1;
                  if (pcnt_ff == cfg_ep_ff - 3'd1) begin
                     state_ff <= root_ph_ff ? ST_CMP : ST_ADDP;
                  end
               end else begin
                  carry_ff <= mul_full[63:p3d_pkg::LIMB_W];
                  limb_ff  <= limb_ff + 2'd1;
               end
            end

            ST_ADDP: begin
               psum_ff  <= psum_ff + term_ff;
               kcnt_ff  <= adv_kcnt;
               pos_ff   <= adv_pos;
               state_ff <= adv_inc ? ST_FINISH : ST_WALK;
            end

            ST_FINISH: begin
               if (tap_cnt_ff == '0) begin
                  rsp_value_ff  <= '0;
                  rsp_status_ff <= p3d_pkg::STAT_EMPTY;
                  rsp_val_ff    <= 1'b1;
                  state_ff      <= ST_OUT;
               end else begin
                  case (cfg_mode_ff)
                     p3d_pkg::MODE_AVG: begin
                        if (cfg_ep_ff == p3d_pkg::AVG_BY_TAPS ||
                            cfg_ep_ff == p3d_pkg::AVG_BY_KERNEL) begin
                           divisor_ff <= (cfg_ep_ff == p3d_pkg::AVG_BY_TAPS) ? tap_cnt_ff
                                                                             : kprod_ff;
                           rem_ff     <= '0;
                           quo_ff     <= sum_abs;
                           neg_ff     <= sum_ff[p3d_pkg::SUM_W-1];
                           dcnt_ff    <= p3d_pkg::DCNT_W'(p3d_pkg::SUM_W - 1);
                           state_ff   <= ST_DIV;
                        end else begin
                           res_ff   <= p3d_pkg::RES_W'(sum_ff);
                           state_ff <= ST_SAT;
                        end
                     end
                     p3d_pkg::MODE_PNORM: begin
                        lo_ff    <= '0;
                        hi_ff    <= p3d_pkg::ROOT_HI;
                        state_ff <= ST_ROOT;
                     end
                     default: begin
                        res_ff   <= p3d_pkg::RES_W'(mx_ff);
                        state_ff <= ST_SAT;
                     end
                  endcase
               end
            end

            ST_DIV: begin
               rem_ff  <= rem_sub[p3d_pkg::TAP_W-1:0];
               quo_ff  <= quo_nxt;
               dcnt_ff <= dcnt_ff - p3d_pkg::DCNT_W'(1);
               if (dcnt_ff == '0) begin
                  // truncate toward zero
                  res_ff   <= neg_ff ? -$signed(p3d_pkg::RES_W'(quo_nxt))
                                     : $signed(p3d_pkg::RES_W'(quo_nxt));
                  state_ff <= ST_SAT;
               end
            end

            ST_ROOT: begin
               if (lo_ff < hi_ff) begin
                  pow_base_ff <= root_mid;
                  term_ff     <= p3d_pkg::PSUM_W'(1);
                  carry_ff    <= '0;
                  limb_ff     <= '0;
                  pcnt_ff     <= '0;
                  root_ph_ff  <= 1'b1;
                  state_ff    <= ST_POW;
               end else begin
                  res_ff   <= p3d_pkg::RES_W'(lo_ff);
                  state_ff <= ST_SAT;
               end
            end

            ST_CMP: begin
               if (term_ff <= psum_ff) lo_ff <= pow_base_ff;
               else                    hi_ff <= pow_base_ff - SB'(1);
               state_ff <= ST_ROOT;
            end

            ST_SAT: begin
               if (res_ff > p3d_pkg::VAL_MAX) begin
                  rsp_value_ff  <= SB'(p3d_pkg::VAL_MAX);
                  rsp_status_ff <= p3d_pkg::STAT_SAT;
               end else if (res_ff < p3d_pkg::VAL_MIN) begin
                  rsp_value_ff  <= SB'(p3d_pkg::VAL_MIN);
                  rsp_status_ff <= p3d_pkg::STAT_SAT;
               end else begin
                  rsp_value_ff  <= res_ff[SB-1:0];
                  rsp_status_ff <= p3d_pkg::STAT_OK;
               end
               rsp_val_ff <= 1'b1;
               state_ff   <= ST_OUT;
            end

            ST_OUT: begin
               if (rsp_chan.ready) begin
                  rsp_val_ff <= 1'b0;
                  state_ff   <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
